// ===== rtl/core/tdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Table DFA matcher package
// Shared widths, command codes and record types for the table-driven matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package tdm_pkg;

	localparam int STATE_W         = 6;
	localparam int SYM_W           = 8;
	localparam int NUM_STATES_DEF  = 64;
	localparam int NUM_SYMBOLS_DEF = 256;

	typedef logic [STATE_W-1:0] state_t;
	typedef logic [SYM_W-1:0]   sym_t;

	localparam state_t START_RST = STATE_W'(1);

	typedef enum logic [1:0] {
		CMD_WR_TRANS = 2'd0,
		CMD_WR_ACC   = 2'd1,
		CMD_STEP     = 2'd2,
		CMD_RESTART  = 2'd3
	} cmd_t;

	// One transition table entry: dead mark over the next state
	typedef struct packed {
		logic   dead;
		state_t nxt;
	} entry_t;

	// Lookup stage record
	typedef struct packed {
		state_t st;
		logic   dead;
		logic   lookup;
		logic   in_range;
	} stage_t;

	// One result item
	typedef struct packed {
		state_t st;
		logic   dead;
		logic   acc;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/core/tdm_if.sv =====
// ----------------------------------------------------------------------------
// Table DFA matcher channels
// Valid/ready interfaces for the command items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdm_item_if;
	import tdm_pkg::*;

	logic   valid;
	logic   ready;
	cmd_t   cmd;
	state_t src_state;
	sym_t   symbol;
	state_t dst_state;
	logic   to_dead;
	logic   accept_bit;
	logic   restart;

	modport source (
		output valid, cmd, src_state, symbol, dst_state, to_dead, accept_bit, restart,
		input  ready
	);
	modport sink (
		input  valid, cmd, src_state, symbol, dst_state, to_dead, accept_bit, restart,
		output ready
	);
endinterface

interface tdm_result_if;
	import tdm_pkg::*;

	logic   valid;
	logic   ready;
	state_t cur_state;
	logic   dead;
	logic   accepted;

	modport source (
		output valid, cur_state, dead, accepted,
		input  ready
	);
	modport sink (
		input  valid, cur_state, dead, accepted,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/tdm_trans_mem.sv =====
// ----------------------------------------------------------------------------
// Transition table memory
// Single-port synchronous table indexed by {state, symbol}, with a clearing
// sweep after reset that writes every entry to state zero, live.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_trans_mem #(
	parameter  int NUM_STATES  = 64,
	parameter  int NUM_SYMBOLS = 256,
	localparam int AW          = $clog2(NUM_STATES) + $clog2(NUM_SYMBOLS)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            rd_en,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   addr,
	input  wire tdm_pkg::entry_t wdata,
	output tdm_pkg::entry_t      rdata,
	output logic                 busy
);
	import tdm_pkg::*;

	localparam int DEPTH = 1 << AW;

	entry_t          mem [DEPTH];
	logic            busy_q;
	logic [AW-1:0]   cnt_q;
	logic            we;
	logic [AW-1:0]   wa;
	entry_t          wd;

	// Sweep every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + AW'(1);
			if (cnt_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Clearing takes the write port while it runs
	always_comb begin
		we = busy_q | wr_en;
		wa = busy_q ? cnt_q : addr;
		wd = busy_q ? '0 : wdata;
	end

	// Storage: read data registered, old data on a same-cycle write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata <= mem[addr];
		end
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

// ===== rtl/core/tdm_acc_mem.sv =====
// ----------------------------------------------------------------------------
// Accepting-state map
// One bit per state, one write and one registered read per cycle, cleared by
// a short sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_acc_mem #(
	parameter  int NUM_STATES = 64,
	localparam int SW         = $clog2(NUM_STATES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [SW-1:0] wr_addr,
	input  wire logic          wr_bit,
	input  wire logic          rd_en,
	input  wire logic [SW-1:0] rd_addr,
	output logic               rd_bit
);
	localparam int DEPTH = 1 << SW;

	logic            mem [DEPTH];
	logic            busy_q;
	logic [SW-1:0]   cnt_q;
	logic            we;
	logic [SW-1:0]   wa;
	logic            wd;

	// Sweep all bits clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + SW'(1);
			if (cnt_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we = busy_q | wr_en;
		wa = busy_q ? cnt_q : wr_addr;
		wd = busy_q ? 1'b0 : wr_bit;
	end

	// Storage: read returns the value before a same-cycle write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_bit <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tdm_out_buf.sv =====
// ----------------------------------------------------------------------------
// Result output buffer
// Output register with a skid entry, so the pipeline is held by a registered
// signal and never by the receiver's ready directly.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_out_buf (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire tdm_pkg::res_t push_data,
	output logic              room,
	tdm_result_if.source      result
);
	import tdm_pkg::*;

	logic out_v_q;
	res_t out_q;
	logic skid_v_q;
	res_t skid_q;
	logic fire;

	assign fire = out_v_q & result.ready;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (fire || !out_v_q) begin
			out_v_q  <= skid_v_q | push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload: refill from the skid entry first
	always_ff @(posedge clk) begin
		if (fire || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign room             = !skid_v_q;
	assign result.valid     = out_v_q;
	assign result.cur_state = out_q.st;
	assign result.dead      = out_q.dead;
	assign result.accepted  = out_q.acc;

endmodule

`default_nettype wire

// ===== rtl/core/table_dfa_matcher.sv =====
// ----------------------------------------------------------------------------
// Table DFA matcher
// Runs a DFA over a symbol stream from a loadable transition table.
// ----------------------------------------------------------------------------
// Usage: the item channel carries four commands. Transition writes and
// accepting-bit writes produce no result; a step (cmd 2, optionally with
// restart) and a restart with the empty string (cmd 3) each produce one
// result with the new state, the sticky dead flag and acceptance.
// The start state register is written through cfg_we/cfg_wdata while idle;
// the user must keep to this, as the block does not enforce it.
// Throughput: one item per cycle while item.ready is high, steps back to back.
// The transition table read data feeds the next lookup address directly,
// which sets the rate. Path: a result passes the table read at the transfer
// edge, the accepting-map read and the output register before it is valid.
// Reset: the transition table is cleared by a sweep of NUM_STATES x
// NUM_SYMBOLS entries (rounded up to powers of two: 16384 at the defaults);
// item.ready stays low until it ends. Run state clears to zero, start state
// returns to 1.
// Stall: a stalled result is held; one more result goes to a skid entry,
// after which item.ready drops until the receiver takes a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module table_dfa_matcher #(
	parameter int NUM_STATES  = tdm_pkg::NUM_STATES_DEF,
	parameter int NUM_SYMBOLS = tdm_pkg::NUM_SYMBOLS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tdm_item_if.sink               item,
	tdm_result_if.source           result,
	input  wire logic              cfg_we,
	input  wire tdm_pkg::state_t   cfg_wdata
);
	import tdm_pkg::*;

	localparam int SW = $clog2(NUM_STATES);
	localparam int YW = $clog2(NUM_SYMBOLS);
	localparam int AW = SW + YW;

	state_t          start_q;
	state_t          run_q;
	logic            dead_q;

	logic            busy;
	logic            room;
	logic            adv;
	logic            take;
	logic            is_res;
	logic            rs;
	state_t          cur_st;
	logic            cur_dead;
	state_t          eff_st;
	logic            eff_dead;
	logic            lookup;
	logic            sym_ok;
	logic            st_ok;
	logic            from_ok;
	logic            tr_rd;
	logic            tr_wr;
	logic [AW-1:0]   tr_addr;
	entry_t          tr_wdata;
	entry_t          tr_rdata;

	logic            valid_s1;
	stage_t          stg_s1;
	state_t          nx_st;
	logic            nx_dead;

	logic            valid_s2;
	state_t          st_s2;
	logic            dead_s2;
	logic            ok_s2;
	logic            acc_bit;
	res_t            res;

	assign adv        = room;
	assign item.ready = room & !busy;
	assign take       = item.valid & item.ready;

	// Start state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RST;
		end else if (cfg_we) begin
			start_q <= cfg_wdata;
		end
	end

	// Issue: forward the state from the lookup stage, apply restart
	always_comb begin
		is_res   = (item.cmd == CMD_STEP) || (item.cmd == CMD_RESTART);
		cur_st   = valid_s1 ? nx_st : run_q;
		cur_dead = valid_s1 ? nx_dead : dead_q;
		rs       = (item.cmd == CMD_RESTART) || item.restart;
		eff_st   = rs ? start_q : cur_st;
		eff_dead = rs ? 1'b0 : cur_dead;
		lookup   = (item.cmd == CMD_STEP) && !eff_dead;
		sym_ok   = 32'(item.symbol) < NUM_SYMBOLS;
		st_ok    = 32'(eff_st) < NUM_STATES;
		from_ok  = 32'(item.src_state) < NUM_STATES;
		tr_wr    = take && (item.cmd == CMD_WR_TRANS) && from_ok && sym_ok;
		tr_rd    = take && lookup && st_ok && sym_ok;
		tr_addr  = (item.cmd == CMD_WR_TRANS) ? {SW'(item.src_state), YW'(item.symbol)}
		                                      : {SW'(eff_st), YW'(item.symbol)};
		tr_wdata = '{dead: item.to_dead, nxt: item.dst_state};
	end

	tdm_trans_mem #(
		.NUM_STATES  (NUM_STATES),
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_trans (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (tr_rd),
		.wr_en  (tr_wr),
		.addr   (tr_addr),
		.wdata  (tr_wdata),
		.rdata  (tr_rdata),
		.busy   (busy)
	);

	// Lookup stage: result items only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= take & is_res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stg_s1 <= '{st: eff_st, dead: eff_dead, lookup: lookup,
			            in_range: st_ok & sym_ok};
		end
	end

	// Resolve the table entry into the next run state
	always_comb begin
		entry_t e;
		e = stg_s1.in_range ? tr_rdata : '0;
		if (stg_s1.lookup) begin
			nx_dead = e.dead;
			nx_st   = e.dead ? '0 : e.nxt;
		end else begin
			nx_dead = stg_s1.dead;
			nx_st   = stg_s1.st;
		end
	end

	// Run state, advanced as each result leaves the lookup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			dead_q <= 1'b0;
		end else if (adv && valid_s1) begin
			run_q  <= nx_st;
			dead_q <= nx_dead;
		end
	end

	tdm_acc_mem #(
		.NUM_STATES (NUM_STATES)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take && (item.cmd == CMD_WR_ACC) && from_ok),
		.wr_addr (SW'(item.src_state)),
		.wr_bit  (item.accept_bit),
		.rd_en   (adv & valid_s1),
		.rd_addr (SW'(nx_st)),
		.rd_bit  (acc_bit)
	);

	// Acceptance stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s2   <= nx_st;
			dead_s2 <= nx_dead;
			ok_s2   <= 32'(nx_st) < NUM_STATES;
		end
	end

	assign res = '{st: st_s2, dead: dead_s2, acc: !dead_s2 & ok_s2 & acc_bit};

	tdm_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv & valid_s2),
		.push_data (res),
		.room      (room),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== rtl/core/tdm_checker.sv =====
// ----------------------------------------------------------------------------
// Table DFA matcher port checker
// Checks result consistency, stall holding and the clearing sweep at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            item_ready,
	input wire logic            res_valid,
	input wire logic            res_ready,
	input wire tdm_pkg::state_t res_state,
	input wire logic            res_dead,
	input wire logic            res_acc
);
	// Table is being cleared on the first edge out of reset
	a_sweep_blocks: assert property (@(posedge clk)
		$rose(arst_n) |-> !item_ready)
		else $error("item ready while the table sweep runs");

	// A dead run reports no state
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_dead |-> res_state == '0)
		else $error("dead result with a non-zero state");

	// A dead run never accepts
	a_dead_no_acc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_acc |-> !res_dead)
		else $error("accepted result while dead");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_state) &&
		$stable(res_dead) && $stable(res_acc))
		else $error("stalled result changed");

endmodule

bind table_dfa_matcher tdm_checker u_tdm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_state  (result.cur_state),
	.res_dead   (result.dead),
	.res_acc    (result.accepted)
);

`default_nettype wire

// ===== tb/table_dfa_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// Table DFA matcher testbench
// Loads small random machines into the transition table, then runs symbol
// strings through them with restarts, dead transitions, table rewrites and
// stray commands mixed in. A scoreboard keeps its own copy of the table,
// the accepting map and the run state, and compares every result transfer
// in order. Both channels idle in random bursts, and the start state
// register is rewritten between phases while the block is quiet.
// ----------------------------------------------------------------------------

module table_dfa_matcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tdm_pkg::*;

	localparam int TABLE_DEPTH   = NUM_STATES_DEF * NUM_SYMBOLS_DEF;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 215;
	localparam int DRAIN_CYCLES  = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int IDLE_PLAN [RANDOM_PHASES] = '{20, 0, 35, 15, 25, 0};

	// Scoreboard: own copy of the matcher and the results still owed
	class dfa_scoreboard;
		entry_t trans_table [TABLE_DEPTH];
		bit     accept_map [NUM_STATES_DEF];
		state_t run_state;
		bit     dead_flag;
		state_t start_state;
		res_t   awaited [$];
		int     errors;

		function new();
			foreach (trans_table[i])
				trans_table[i] = '0;
			foreach (accept_map[i])
				accept_map[i] = 1'b0;
			run_state   = '0;
			dead_flag   = 1'b0;
			start_state = START_RST;
			errors      = 0;
		endfunction

		function void flag_error(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("[%0t] %s", $realtime, msg);
		endfunction

		// Apply one accepted command and queue the result it owes
		function void note_item(cmd_t cmd, state_t from, sym_t sym, state_t to,
				bit to_dead, bit acc_bit, bit restart);
			entry_t hop;
			res_t   res;
			case (cmd)
				CMD_WR_TRANS: begin
					trans_table[{from, sym}] = {to_dead, to};
				end
				CMD_WR_ACC: begin
					accept_map[from] = acc_bit;
				end
				default: begin
					if (cmd == CMD_RESTART || restart) begin
						run_state = start_state;
						dead_flag = 1'b0;
					end
					// advance through the table unless already dead
					if (cmd == CMD_STEP && !dead_flag) begin
						hop = trans_table[{run_state, sym}];
						if (hop.dead) begin
							dead_flag = 1'b1;
							run_state = '0;
						end else begin
							run_state = hop.nxt;
						end
					end
					res.st   = dead_flag ? state_t'(0) : run_state;
					res.dead = dead_flag;
					res.acc  = dead_flag ? 1'b0 : accept_map[run_state];
					awaited.push_back(res);
				end
			endcase
		endfunction

		// Compare one result transfer with the oldest expectation
		function void check_result(state_t st, logic dead, logic acc);
			res_t want;
			if (awaited.size() == 0) begin
				flag_error($sformatf("result with nothing expected: state %0d dead %b acc %b",
					st, dead, acc));
				return;
			end
			want = awaited.pop_front();
			if (want.st !== st || want.dead !== dead || want.acc !== acc)
				flag_error($sformatf({"result mismatch: expected state %0d dead %b acc %b,",
					" got state %0d dead %b acc %b"},
					want.st, want.dead, want.acc, st, dead, acc));
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n;
	logic   cfg_we;
	state_t cfg_wdata;
	int     idle_pct;
	int     stall_left = 0;
	int     cycle_count = 0;

	dfa_scoreboard sb;

	tdm_item_if   item_ch ();
	tdm_result_if result_ch ();

	table_dfa_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Random single bit
	function automatic bit coin();
		return 1'($urandom_range(0, 1));
	endfunction

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("table_dfa_matcher verification failed");
			$finish;
		end
	end

	// Receiver: drop ready in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			result_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Check each result transfer at the falling edge ahead of its transfer edge
	always @(negedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.cur_state, result_ch.dead, result_ch.accepted);
	end

	// Present one command and hold it until the transfer, then maybe idle
	task automatic send_item(cmd_t cmd, state_t from, sym_t sym, state_t to,
			bit to_dead, bit acc_bit, bit restart);
		item_ch.valid      <= 1'b1;
		item_ch.cmd        <= cmd;
		item_ch.src_state  <= from;
		item_ch.symbol     <= sym;
		item_ch.dst_state  <= to;
		item_ch.to_dead    <= to_dead;
		item_ch.accept_bit <= acc_bit;
		item_ch.restart    <= restart;
		@(negedge clk);
		while (!item_ch.ready)
			@(negedge clk);
		@(posedge clk);
		sb.note_item(cmd, from, sym, to, to_dead, acc_bit, restart);
		if ($urandom_range(0, 99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Hold the sender until every owed result has arrived and writes settle
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_start(state_t value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.start_state = value;
	endtask

	// Load a small random machine, then run strings through it with noise
	task automatic run_phase(int quota, bit hold_mid);
		state_t states [6];
		sym_t   alphabet [5];
		int     n_st;
		int     n_sym;
		int     done;
		int     pick;
		bit     kill;
		state_t nxt;
		sym_t   sym;
		n_st = $urandom_range(2, 6);
		n_sym = $urandom_range(2, 5);
		states[0] = sb.start_state;
		for (int i = 1; i < n_st; i++)
			states[i] = state_t'($urandom);
		for (int i = 0; i < n_sym; i++)
			alphabet[i] = sym_t'($urandom);
		if ($urandom_range(0, 2) == 0)
			alphabet[0] = '0;
		if ($urandom_range(0, 2) == 0)
			alphabet[n_sym-1] = '1;
		done = 0;

		// load transitions, a few dead or leading outside the machine
		for (int i = 0; i < n_st; i++) begin
			for (int j = 0; j < n_sym; j++) begin
				kill = ($urandom_range(0, 11) == 0);
				nxt = (kill || $urandom_range(0, 9) == 0) ? state_t'($urandom) :
					states[$urandom_range(0, n_st-1)];
				send_item(CMD_WR_TRANS, states[i], alphabet[j], nxt, kill,
					coin(), coin());
				done++;
			end
		end
		for (int i = 0; i < n_st; i++) begin
			send_item(CMD_WR_ACC, states[i], sym_t'($urandom), state_t'($urandom),
				coin(), coin(), coin());
			done++;
		end

		// run symbol strings
		while (done < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_item(cmd_t'($urandom_range(0, 3)), state_t'($urandom), sym_t'($urandom),
					state_t'($urandom), coin(), coin(), coin());
			end else if (pick < 14) begin
				send_item(CMD_RESTART, state_t'($urandom), sym_t'($urandom), state_t'($urandom),
					coin(), coin(), coin());
			end else if (pick < 19) begin
				kill = ($urandom_range(0, 7) == 0);
				send_item(CMD_WR_TRANS, states[$urandom_range(0, n_st-1)],
					alphabet[$urandom_range(0, n_sym-1)],
					states[$urandom_range(0, n_st-1)], kill,
					coin(), coin());
			end else if (pick < 22) begin
				send_item(CMD_WR_ACC, states[$urandom_range(0, n_st-1)], sym_t'($urandom),
					state_t'($urandom), coin(), coin(), coin());
			end else begin
				sym = ($urandom_range(0, 9) == 0) ? sym_t'($urandom) :
					alphabet[$urandom_range(0, n_sym-1)];
				send_item(CMD_STEP, state_t'($urandom), sym, state_t'($urandom),
					coin(), coin(), $urandom_range(0, 6) == 0);
			end
			done++;
			if (hold_mid && done == quota / 2)
				drain();
		end
	endtask

	initial begin
		sb = new();
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		item_ch.valid         = 1'b0;
		item_ch.cmd           = CMD_WR_TRANS;
		item_ch.src_state     = '0;
		item_ch.symbol        = '0;
		item_ch.dst_state     = '0;
		item_ch.to_dead       = 1'b0;
		item_ch.accept_bit    = 1'b0;
		item_ch.restart       = 1'b0;
		idle_pct              = 20;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait out the table clearing sweep
		@(negedge clk);
		while (!item_ch.ready)
			@(negedge clk);
		@(posedge clk);

		// step before any restart runs from the zero row
		send_item(CMD_STEP, '0, 8'h00, '0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_RESTART, '1, '1, '1, 1'b1, 1'b1, 1'b0);
		// accepting bits, restart flag on writes does nothing
		send_item(CMD_WR_ACC, 6'd1, '0, '0, 1'b0, 1'b1, 1'b1);
		send_item(CMD_WR_ACC, 6'd63, '1, '1, 1'b1, 1'b1, 1'b0);
		send_item(CMD_WR_ACC, 6'd0, '0, '0, 1'b0, 1'b1, 1'b0);
		send_item(CMD_WR_TRANS, 6'd1, 8'hFF, 6'd63, 1'b0, 1'b0, 1'b1);
		send_item(CMD_WR_TRANS, 6'd63, 8'h00, 6'd42, 1'b1, 1'b1, 1'b0);
		send_item(CMD_WR_TRANS, 6'd0, 8'hAA, 6'd1, 1'b0, 1'b0, 1'b0);
		// live run, then a dead transition that sticks
		send_item(CMD_RESTART, '0, '0, '0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_STEP, '0, 8'hFF, '0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_STEP, '0, 8'h00, '0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_STEP, '0, 8'hFF, '0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_RESTART, '0, '0, '0, 1'b0, 1'b0, 1'b1);
		// unwritten entry drops into the zero row, which is an ordinary row
		send_item(CMD_STEP, '0, 8'h07, '0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_STEP, '0, 8'hAA, '0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_STEP, '0, 8'h55, '0, 1'b0, 1'b0, 1'b1);
		// dead mark with a non-zero next state still reads as dead
		send_item(CMD_WR_TRANS, 6'd63, 8'hFF, 6'd63, 1'b1, 1'b0, 1'b0);
		send_item(CMD_STEP, '0, 8'hFF, '0, 1'b0, 1'b0, 1'b1);
		send_item(CMD_STEP, '0, 8'hFF, '0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_WR_ACC, 6'd63, '0, '0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_STEP, '0, 8'hFF, '0, 1'b0, 1'b0, 1'b1);
		drain();
		write_start('1);
		send_item(CMD_RESTART, '0, '0, '0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_STEP, '0, 8'h00, '0, 1'b0, 1'b0, 1'b0);

		// random phases, each under its own start state
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			idle_pct = IDLE_PLAN[p];
			if (p == 0)
				write_start(START_RST);
			else if (p == 2)
				write_start('1);
			else
				write_start(state_t'($urandom_range(1, 63)));
			run_phase(PHASE_ITEMS, p == 1);
		end

		drain();
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("table_dfa_matcher verification clean");
		else
			$display("table_dfa_matcher verification failed");
		$finish;
	end

endmodule
